// File: src/assert_macros.svh
// Assertion helpers shared by the RTL of the GF(2^128) accumulate block.
// Each macro places one labeled concurrent assertion that is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHECK_SAME(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHECK_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: src/gfmac_pkg.sv
// ----------------------------------------------------------------------------
// gfmac_pkg
// Types, constants and field arithmetic helpers for the GF(2^128) accumulate
// block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gfmac_pkg;

  localparam int BLOCK_W     = 128;
  localparam int HALF_W      = 64;
  localparam int DIGIT_W     = 32;
  localparam int NUM_DIGITS  = BLOCK_W / DIGIT_W;
  localparam int BLOCK_BYTES = BLOCK_W / 8;
  localparam int LEN_SHIFT   = 3;

  // x^128 = x^7 + x^2 + x + 1
  localparam logic [7:0] REDUCTION = 8'h87;

  localparam int QUEUE_DEPTH_DEF  = 2;
  localparam int RESULT_DEPTH_DEF = 2;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_LENGTH = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_MUL,
    KIND_HOLD
  } kind_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [HALF_W-1:0] a_hi;
    logic [HALF_W-1:0] a_lo;
    logic [4:0]        valid_bytes;
    logic [HALF_W-1:0] key_hi;
    logic [HALF_W-1:0] key_lo;
  } in_item_t;

  typedef struct packed {
    logic [HALF_W-1:0] product_hi;
    logic [HALF_W-1:0] product_lo;
    logic [HALF_W-1:0] sum_hi;
    logic [HALF_W-1:0] sum_lo;
  } out_item_t;

  // Classified work item handed from the front end to the multiplier.
  typedef struct packed {
    kind_t              kind;
    logic [BLOCK_W-1:0] a;
    logic [BLOCK_W-1:0] key;
  } work_t;

  // Fold a digit that overflowed past x^127 back into the field.
  function automatic logic [BLOCK_W-1:0] gf_fold(input logic [DIGIT_W-1:0] h);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      if (REDUCTION[b]) begin
        r = r ^ (BLOCK_W'(h) << b);
      end
    end
    return r;
  endfunction

  // a times one digit of the multiplier, reduced.
  function automatic logic [BLOCK_W-1:0] gf_mul_digit(input logic [BLOCK_W-1:0] a,
                                                      input logic [DIGIT_W-1:0] d);
    logic [BLOCK_W+DIGIT_W-1:0] full;
    full = '0;
    for (int j = 0; j < DIGIT_W; j++) begin
      if (d[j]) begin
        full = full ^ ((BLOCK_W + DIGIT_W)'(a) << j);
      end
    end
    return full[BLOCK_W-1:0] ^ gf_fold(full[BLOCK_W+DIGIT_W-1:BLOCK_W]);
  endfunction

  // a times x^DIGIT_W, reduced.
  function automatic logic [BLOCK_W-1:0] gf_shift_digit(input logic [BLOCK_W-1:0] a);
    return (a << DIGIT_W) ^ gf_fold(a[BLOCK_W-1 -: DIGIT_W]);
  endfunction

endpackage

`default_nettype wire

// File: src/gfmac_fifo.sv
// ----------------------------------------------------------------------------
// gfmac_fifo
// Small first-in first-out queue built from registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gfmac_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  `CHECK_NEXT(fifo_fill, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1, "fifo count did not grow on push")
  `CHECK_NEXT(fifo_drain, clk, rst, do_pop && !do_push, count == $past(count) - 1'b1, "fifo count did not shrink on pop")

endmodule

`default_nettype wire

// File: src/gfmac_front.sv
// ----------------------------------------------------------------------------
// gfmac_front
// Decodes the operation of an incoming item and forms the 128-bit operand.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gfmac_front (
  input  gfmac_pkg::in_item_t item,
  output gfmac_pkg::work_t    work
);

  import gfmac_pkg::*;

  logic [4:0]         nb;
  logic [BLOCK_W-1:0] keep;

  // Byte k of the block counts from the most significant end.
  always_comb begin
    nb   = (item.valid_bytes > 5'(BLOCK_BYTES)) ? 5'(BLOCK_BYTES) : item.valid_bytes;
    keep = '0;
    for (int k = 0; k < BLOCK_BYTES; k++) begin
      keep[BLOCK_W-1-8*k -: 8] = (5'(k) < nb) ? 8'hFF : 8'h00;
    end
  end

  always_comb begin
    work.key = {item.key_hi, item.key_lo};
    unique case (item.op)
      OP_CLEAR: begin
        work.kind = KIND_CLEAR;
        work.a    = '0;
      end
      OP_DATA: begin
        work.kind = KIND_MUL;
        work.a    = {item.a_hi, item.a_lo} & keep;
      end
      OP_LENGTH: begin
        // Byte counts become bit counts, each modulo 2^64.
        work.kind = KIND_MUL;
        work.a    = {item.a_hi << LEN_SHIFT, item.a_lo << LEN_SHIFT};
      end
      default: begin
        work.kind = KIND_HOLD;
        work.a    = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/gfmac_back.sv
// ----------------------------------------------------------------------------
// gfmac_back
// Digit-pipelined field multiplier, accumulator and result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gfmac_back #(
  parameter int RESULT_DEPTH = gfmac_pkg::RESULT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gfmac_pkg::work_t     work,
  input  logic                 work_valid,
  output logic                 work_take,
  output gfmac_pkg::out_item_t result,
  output logic                 empty,
  input  logic                 pop
);

  import gfmac_pkg::*;

  localparam int NS = NUM_DIGITS;

  logic [NS:0]        p_valid;
  kind_t              p_kind [NS+1];
  logic [BLOCK_W-1:0] p_a    [NS];
  logic [BLOCK_W-1:0] p_key  [NS];
  logic [BLOCK_W-1:0] p_t    [1:NS];
  logic [BLOCK_W-1:0] acc;
  logic [BLOCK_W-1:0] sum;
  logic               advance;
  logic               res_full;
  logic               res_push;
  out_item_t          res_item;

  // The whole pipe holds only while its last stage waits on a full queue.
  assign advance   = !(p_valid[NS] && res_full);
  assign work_take = advance && work_valid;
  assign res_push  = p_valid[NS] && !res_full;

  assign sum = (p_kind[NS] == KIND_CLEAR) ? '0 : (acc ^ p_t[NS]);

  assign res_item.product_hi = p_t[NS][BLOCK_W-1 -: HALF_W];
  assign res_item.product_lo = p_t[NS][HALF_W-1:0];
  assign res_item.sum_hi     = sum[BLOCK_W-1 -: HALF_W];
  assign res_item.sum_lo     = sum[HALF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= '0;
      acc     <= '0;
    end else begin
      if (advance) begin
        p_valid <= {p_valid[NS-1:0], work_valid};
      end
      if (res_push) begin
        acc <= sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_kind[0] <= work.kind;
      p_a[0]    <= work.a;
      p_key[0]  <= work.key;
      p_kind[1] <= p_kind[0];
      p_t[1]    <= gf_mul_digit(p_a[0], p_key[0][DIGIT_W-1:0]);
      for (int k = 1; k < NS; k++) begin
        p_kind[k+1] <= p_kind[k];
        p_a[k]      <= gf_shift_digit(p_a[k-1]);
        p_key[k]    <= p_key[k-1];
        p_t[k+1]    <= p_t[k] ^ gf_mul_digit(p_a[k], p_key[k][k*DIGIT_W +: DIGIT_W]);
      end
    end
  end

  gfmac_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(RESULT_DEPTH)
  ) u_result_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_item),
    .full (res_full),
    .pop  (pop),
    .dout (result),
    .empty(empty)
  );

  `CHECK_NEXT(back_clear, clk, rst, res_push && (p_kind[NS] == KIND_CLEAR), acc == '0, "accumulator not cleared")
  `CHECK_NEXT(back_stall_hold, clk, rst, p_valid[NS] && res_full, p_valid[NS] && (p_t[NS] == $past(p_t[NS])), "stalled product changed")
  `CHECK_SAME(back_take_room, clk, rst, work_take, !(p_valid[NS] && res_full), "item taken during stall")

endmodule

`default_nettype wire

// File: src/gf128_multiply_accumulate.sv
// The multiplier runs as four 32-bit digit stages between the work and result queues.
// Throughput: one item per cycle while no full result queue stalls the pipe.
// Either side may stall on its own; a two-entry queue sits on each side of the multiplier.
// Reset (rst, synchronous): both queues empty, the pipe holds nothing, accumulator zero.
// ----------------------------------------------------------------------------
// gf128_multiply_accumulate
// MGM authentication core: multiplies each block by its key block in
// GF(2^128), folds the product into a 128-bit running sum; clear zeroes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gf128_multiply_accumulate #(
  parameter int QUEUE_DEPTH  = gfmac_pkg::QUEUE_DEPTH_DEF,
  parameter int RESULT_DEPTH = gfmac_pkg::RESULT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  gfmac_pkg::in_item_t  item,
  output logic                 empty,
  input  logic                 pop,
  output gfmac_pkg::out_item_t result
);

  import gfmac_pkg::*;

  // The front end decodes the operation in the cycle of the transfer: clear
  // and reserved codes carry a zero operand, so the multiplier yields a zero
  // product for them; data blocks are masked to their valid leading bytes and
  // length blocks turn byte counts into bit counts.
  work_t front_work;
  work_t queued_work;
  logic  work_empty;
  logic  work_take;

  gfmac_front u_front (
    .item(item),
    .work(front_work)
  );

  // Work queue between the decoder and the multiplier. The input side only
  // sees this queue, so a transfer is taken whenever it has room.
  gfmac_fifo #(
    .WIDTH($bits(work_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_work_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (front_work),
    .full (full),
    .pop  (work_take),
    .dout (queued_work),
    .empty(work_empty)
  );

  // The back end multiplies one 32-bit key digit per stage, then updates the
  // accumulator as each result enters the result queue, in arrival order.
  gfmac_back #(
    .RESULT_DEPTH(RESULT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .work      (queued_work),
    .work_valid(!work_empty),
    .work_take (work_take),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

`default_nettype wire
